FILE: design/pmfb_pkg.sv
// Shared types, constants and the splash image for the paged mono frame buffer.
package pmfb_pkg;

  localparam int DEF_DISPLAY_WIDTH  = 84;
  localparam int DEF_DISPLAY_HEIGHT = 48;

  // Splash image size and the index width that covers the largest store.
  localparam int SPLASH_BYTES = 504;
  localparam int IDX_W        = 13;

  localparam logic [7:0] CMD_PAGE   = 8'h40;
  localparam logic [7:0] CMD_COLUMN = 8'h80;

  // Configuration register indexes.
  localparam logic REG_ROTATION = 1'b0;
  localparam logic REG_TRAILER  = 1'b1;

  // Result kinds.
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_REFRESH = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REFRESH = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FIN,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
    logic sweep;
    logic sweep_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    sweep_last;
    logic    out_free;
  } ctrl_status_t;

  localparam logic [7:0] SPLASH_ROM [SPLASH_BYTES] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'hE0,
    8'hF0, 8'hF8, 8'hFC, 8'hFC, 8'hFE, 8'hFF, 8'hFC, 8'hE0,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF8, 8'hF8, 8'hF8,
    8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8,
    8'hF8, 8'hF0, 8'hF0, 8'hE0, 8'hE0, 8'hC0, 8'h80, 8'hC0,
    8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h3F, 8'h7F,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hE7, 8'hC7,
    8'hC7, 8'h87, 8'h8F, 8'h9F, 8'h9F, 8'hFF, 8'hFF, 8'hFF,
    8'hC1, 8'hC0, 8'hE0, 8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFC, 8'hFC, 8'hFC, 8'hFC, 8'hFE, 8'hFE, 8'hFE,
    8'hFC, 8'hFC, 8'hF8, 8'hF8, 8'hF0, 8'hE0, 8'hC0, 8'hC0,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF1, 8'hFB, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h0F, 8'h0F, 8'h87,
    8'hE7, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'h1F, 8'h3F, 8'hF9,
    8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hFD, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h7F, 8'h3F, 8'h0F, 8'h07, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hF0, 8'hFE, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
    8'h7E, 8'h3F, 8'h3F, 8'h0F, 8'h1F, 8'hFF, 8'hFF, 8'hFF,
    8'hFC, 8'hF0, 8'hE0, 8'hF1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFC, 8'hF0, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03,
    8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h03, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'h7F,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h1F, 8'h03,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Splash byte for a store index; bytes past the image are blank.
  function automatic logic [7:0] splash_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < IDX_W'(SPLASH_BYTES)) begin
      b = SPLASH_ROM[idx[8:0]];
    end
    return b;
  endfunction

endpackage

FILE: design/paged_mono_framebuffer_core.sv
// Top level of the paged mono frame buffer: ports, configuration registers, wiring.
//
// A monochrome frame store of DISPLAY_WIDTH columns by DISPLAY_HEIGHT rows, held as
// pages of eight rows per byte. Each word on the slave stream is one command, chosen
// by tuser: write a pixel, read a pixel, clear the store, or fetch the next refresh
// byte. Pixel coordinates pass through the rotation register first; pixels outside
// the logical area are dropped on write and read back as 0. Reads and refresh
// fetches each return one word on the master stream; writes and clears return none.
// The configuration channel is always ready and is meant to be written while idle.
//
// A write, read or refresh word first looks up the store, then modifies or formats
// in a final step; a new word is accepted during that final step and not before,
// since the read-modify-write goes through the synchronous store. The result word
// is loaded into the output register at the end of the final step. A clear walks
// the store one byte a cycle and keeps tready low until its sweep has finished.
// After reset the same sweep loads the splash image before tready rises.
// The output word sits in a register: a new word is accepted while it waits, and
// a word that owes a result holds in its final step while the receiver stalls.
module paged_mono_framebuffer_core #(
  parameter int DISPLAY_WIDTH  = pmfb_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = pmfb_pkg::DEF_DISPLAY_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] x, [15:8] y, [16] ink, rest zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] pixel, [8:1] out_byte, rest zero
  output logic [1:0]  m_axis_tuser_o,   // [0] result_kind, [1] is_command
  output logic        m_axis_tlast_o,   // last_of_frame
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i
);
  import pmfb_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Configuration registers: rotation and the end-of-frame trailer enable.
  logic [1:0] rotation_q;
  logic       send_trailer_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q     <= 2'd0;
      send_trailer_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROTATION: rotation_q     <= cfg_data_i;
        REG_TRAILER:  send_trailer_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic       out_kind, out_pixel, out_cmd;
  logic [7:0] out_byte;

  pmfb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  pmfb_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .rotation_i     (rotation_q),
    .send_trailer_i (send_trailer_q),
    .opcode_i       (s_axis_tuser_i),
    .x_i            (s_axis_tdata_i[7:0]),
    .y_i            (s_axis_tdata_i[15:8]),
    .ink_i          (s_axis_tdata_i[16]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_kind_o     (out_kind),
    .out_pixel_o    (out_pixel),
    .out_byte_o     (out_byte),
    .out_cmd_o      (out_cmd),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, out_byte, out_pixel};
  assign m_axis_tuser_o = {out_cmd, out_kind};

endmodule

FILE: design/pmfb_ctrl.sv
// Sequencing state machine of the paged mono frame buffer.
module pmfb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  pmfb_pkg::ctrl_status_t status_i,
  output pmfb_pkg::ctrl_cmd_t    cmd_o
);
  import pmfb_pkg::*;

  state_e state_q, state_d;
  logic   fin_ok;
  logic   accept;

  // The finishing step only stalls when it owes a result and the output slot is busy.
  assign fin_ok = !(status_i.op == OP_READ || status_i.op == OP_REFRESH) || status_i.out_free;
  assign s_axis_tready_o = (state_q == ST_IDLE) || ((state_q == ST_FIN) && fin_ok);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = (status_i.op == OP_CLEAR) ? ST_CLEAR : ST_FIN;
      end
      ST_FIN: begin
        if (fin_ok) state_d = accept ? ST_EXEC : ST_IDLE;
      end
      ST_CLEAR: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.capture     = accept;
    cmd_o.exec        = (state_q == ST_EXEC);
    cmd_o.finish      = (state_q == ST_FIN) && fin_ok;
    cmd_o.sweep       = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.sweep_clear = (state_q == ST_CLEAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_INIT |=> state_q != ST_INIT)
    else $error("frame buffer returned to the initial fill");

  a_sweep_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep |-> !cmd_o.capture && !cmd_o.finish)
    else $error("store sweep overlaps item handling");

  a_clear_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_CLEAR) |-> $past(state_q == ST_EXEC))
    else $error("clear sweep started without a clear item");

endmodule

FILE: design/pmfb_datapath.sv
// Item registers, coordinate mapping, frame store, refresh counters and output word.
module pmfb_datapath #(
  parameter int DISPLAY_WIDTH  = pmfb_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = pmfb_pkg::DEF_DISPLAY_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pmfb_pkg::ctrl_cmd_t    cmd_i,
  output pmfb_pkg::ctrl_status_t status_o,
  input  logic [1:0]             rotation_i,
  input  logic                   send_trailer_i,
  input  logic [1:0]             opcode_i,
  input  logic signed [7:0]      x_i,
  input  logic signed [7:0]      y_i,
  input  logic                   ink_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_kind_o,
  output logic                   out_pixel_o,
  output logic [7:0]             out_byte_o,
  output logic                   out_cmd_o,
  output logic                   out_last_o
);
  import pmfb_pkg::*;

  localparam int NUM_PAGES   = DISPLAY_HEIGHT / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * NUM_PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);
  localparam int PAGE_W      = $clog2(NUM_PAGES + 1);
  localparam int OFF_W       = $clog2(DISPLAY_WIDTH + 2);
  localparam int C_W         = 11;

  localparam logic signed [C_W-1:0] W_S    = C_W'(DISPLAY_WIDTH);
  localparam logic signed [C_W-1:0] H_S    = C_W'(DISPLAY_HEIGHT);
  localparam logic signed [C_W-1:0] ROWS_S = C_W'(NUM_PAGES * 8);
  localparam logic [PAGE_W-1:0]     PAGE_END  = PAGE_W'(NUM_PAGES);
  localparam logic [PAGE_W-1:0]     PAGE_LAST = PAGE_W'(NUM_PAGES - 1);
  localparam logic [OFF_W-1:0]      OFF_LAST  = OFF_W'(DISPLAY_WIDTH + 1);
  localparam logic [CNT_W-1:0]      CNT_END   = CNT_W'(STORE_BYTES);

  // Item registers.
  opcode_e           op_q;
  logic signed [7:0] x_q, y_q;
  logic              ink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_WRITE;
    end else if (cmd_i.capture) begin
      op_q <= opcode_e'(opcode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= x_i;
      y_q   <= y_i;
      ink_q <= ink_i;
    end
  end

  // Rotation and range check.
  logic signed [C_W-1:0] xs, ys, lw, lh, col, row;
  logic                  in_area, loc_ok;
  logic [IDX_W-1:0]      loc_full;
  logic [ADDR_W-1:0]     loc_idx;

  always_comb begin
    xs = C_W'(x_q);
    ys = C_W'(y_q);
    lw = rotation_i[0] ? H_S : W_S;
    lh = rotation_i[0] ? W_S : H_S;
    in_area = !xs[C_W-1] && (xs < lw) && !ys[C_W-1] && (ys < lh);
    case (rotation_i)
      2'd1: begin
        col = ys;
        row = H_S - C_W'(1) - xs;
      end
      2'd2: begin
        col = W_S - C_W'(1) - xs;
        row = H_S - C_W'(1) - ys;
      end
      2'd3: begin
        col = W_S - C_W'(1) - ys;
        row = xs;
      end
      default: begin
        col = xs;
        row = ys;
      end
    endcase
    loc_ok = in_area && !col[C_W-1] && (col < W_S) && !row[C_W-1] && (row < ROWS_S);
    loc_full = IDX_W'(col[7:0]) + IDX_W'(row[6:3]) * IDX_W'(DISPLAY_WIDTH);
    loc_idx  = loc_full[ADDR_W-1:0];
  end

  logic              loc_ok_q;
  logic [ADDR_W-1:0] loc_idx_q;
  logic [2:0]        loc_bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      loc_ok_q  <= loc_ok;
      loc_idx_q <= loc_idx;
      loc_bit_q <= row[2:0];
    end
  end

  // Refresh position as page, offset within page and data byte address.
  logic [PAGE_W-1:0] page_q, page_d, page_e;
  logic [OFF_W-1:0]  off_q, off_d, off_e;
  logic [CNT_W-1:0]  raddr_q, raddr_d, raddr_e;
  logic              wrap, trailer_pos, ref_last;
  logic [7:0]        ref_byte;
  logic              ref_cmd;
  logic [7:0]        rdata_q;

  always_comb begin
    // Position left on the trailer slot after the trailer was switched off.
    wrap        = (page_q == PAGE_END) && !send_trailer_i;
    page_e      = wrap ? '0 : page_q;
    off_e       = wrap ? '0 : off_q;
    raddr_e     = wrap ? '0 : raddr_q;
    trailer_pos = (page_e == PAGE_END);
    ref_last    = trailer_pos ||
                  (!send_trailer_i && (page_e == PAGE_LAST) && (off_e == OFF_LAST));
    if (trailer_pos) begin
      ref_byte = CMD_PAGE;
      ref_cmd  = 1'b1;
    end else if (off_e == OFF_W'(0)) begin
      ref_byte = CMD_PAGE | 8'(page_e);
      ref_cmd  = 1'b1;
    end else if (off_e == OFF_W'(1)) begin
      ref_byte = CMD_COLUMN;
      ref_cmd  = 1'b1;
    end else begin
      ref_byte = rdata_q;
      ref_cmd  = 1'b0;
    end
    page_d  = page_e;
    off_d   = off_e;
    raddr_d = raddr_e;
    if (ref_last) begin
      page_d  = '0;
      off_d   = '0;
      raddr_d = '0;
    end else if (off_e == OFF_LAST) begin
      page_d  = page_e + PAGE_W'(1);
      off_d   = '0;
      raddr_d = raddr_e + CNT_W'(1);
    end else begin
      off_d = off_e + OFF_W'(1);
      if (off_e >= OFF_W'(2)) raddr_d = raddr_e + CNT_W'(1);
    end
  end

  logic ref_commit;
  assign ref_commit = cmd_i.finish && (op_q == OP_REFRESH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      off_q   <= '0;
      raddr_q <= '0;
    end else if (ref_commit) begin
      page_q  <= page_d;
      off_q   <= off_d;
      raddr_q <= raddr_d;
    end
  end

  // Sweep counter for the splash fill and the clear; the write uses the previous count
  // so the splash table read can be registered.
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_prev;
  logic [7:0]       rom_q;
  logic             sweep_last;

  assign sweep_last = (cnt_q == CNT_END);
  assign cnt_d      = (cmd_i.sweep && !sweep_last) ? cnt_q + CNT_W'(1) : '0;
  assign cnt_prev   = cnt_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= splash_byte(IDX_W'(cnt_q));
  end

  // Frame store.
  logic [7:0]        mem_q [STORE_BYTES];
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, mask;

  always_comb begin
    mask = 8'h01 << loc_bit_q;
    if (cmd_i.sweep) begin
      we    = (cnt_q != '0);
      waddr = cnt_prev[ADDR_W-1:0];
      wdata = cmd_i.sweep_clear ? 8'h00 : rom_q;
    end else begin
      we    = cmd_i.finish && (op_q == OP_WRITE) && loc_ok_q;
      waddr = loc_idx_q;
      wdata = ink_q ? (rdata_q | mask) : (rdata_q & ~mask);
    end
    raddr = (op_q == OP_REFRESH) ? raddr_e[ADDR_W-1:0] : loc_idx;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.exec) rdata_q <= mem_q[raddr];
  end

  // Output word register.
  logic out_valid_q, out_load;
  logic out_kind_q, out_pixel_q, out_cmd_q, out_last_q;
  logic [7:0] out_byte_q;

  assign out_load = cmd_i.finish && ((op_q == OP_READ) || (op_q == OP_REFRESH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (op_q == OP_REFRESH) begin
        out_kind_q  <= KIND_REFRESH;
        out_pixel_q <= 1'b0;
        out_byte_q  <= ref_byte;
        out_cmd_q   <= ref_cmd;
        out_last_q  <= ref_last;
      end else begin
        out_kind_q  <= KIND_PIXEL;
        out_pixel_q <= loc_ok_q & rdata_q[loc_bit_q];
        out_byte_q  <= 8'h00;
        out_cmd_q   <= 1'b0;
        out_last_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_pixel_o = out_pixel_q;
  assign out_byte_o  = out_byte_q;
  assign out_cmd_o   = out_cmd_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    status_o            = '0;
    status_o.op         = op_q;
    status_o.sweep_last = sweep_last;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ref_commit && ref_last) |=> (page_q == '0) && (off_q == '0) && (raddr_q == '0))
    else $error("refresh position did not wrap after the last byte of a frame");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (page_q <= PAGE_END) && (off_q <= OFF_LAST) && (raddr_q <= CNT_END))
    else $error("refresh position out of range");

endmodule

FILE: test/paged_mono_framebuffer_core_tb.sv
// Self-checking testbench for the paged mono frame buffer core.
`timescale 1ns / 100ps

module paged_mono_framebuffer_core_tb;
  import pmfb_pkg::*;

  localparam int DISP_W     = DEF_DISPLAY_WIDTH;
  localparam int DISP_H     = DEF_DISPLAY_HEIGHT;
  localparam int PAGES      = DISP_H / 8;
  localparam int STORE_SIZE = DISP_W * PAGES;
  localparam int PER_PAGE   = DISP_W + 2;
  localparam int FRAME_BODY = PAGES * PER_PAGE;
  // A clear keeps the block busy without any result until its sweep is done,
  // so every drain waits longer than a whole clear before touching the registers.
  localparam int SETTLE     = STORE_SIZE + 100;
  // Longest legitimate quiet stretch is the clear or the reset sweep or the long
  // receiver hold-off; the watchdog allows several times that.
  localparam int WATCHDOG   = 4000;
  localparam int HOLD_OFF   = 300;

  // One command word as the sender sees it.
  typedef struct packed {
    opcode_e    op;
    logic [7:0] x;
    logic [7:0] y;
    logic       ink;
  } fb_cmd_t;

  // One result word, field by field.
  typedef struct packed {
    logic       kind;
    logic       pixel;
    logic [7:0] out_byte;
    logic       is_cmd;
    logic       last;
  } fb_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fb_cmd_t     s_cmd   = '0;
  logic        s_valid = 1'b0;
  logic        m_rdy   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_data  = 2'b00;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_ready_o;
  logic [23:0] s_axis_tdata_i;

  // x in the low byte, then y, then ink; the upper bits stay zero.
  assign s_axis_tdata_i = {7'd0, s_cmd.ink, s_cmd.y, s_cmd.x};

  paged_mono_framebuffer_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_cmd.op),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the block: pixel store, refresh pointer and both registers.
  logic [7:0] shadow_store [STORE_SIZE];
  int         shadow_pos;
  logic [1:0] shadow_rot;
  logic       shadow_trailer;

  fb_cmd_t    cmd_q[$];          // words waiting to be offered
  fb_result_t results_due[$];    // results the block still owes, oldest first
  int         errors = 0;

  // Handshake flags seen at the last rising edge, used by the falling-edge drivers.
  logic       s_took = 1'b0;
  logic       m_took = 1'b0;
  // Run-time knobs set by the stimulus: calm turns off all random idling, and
  // toggling hold_req asks the receiver for one long hold-off.
  bit         calm     = 1'b0;
  bit         hold_req = 1'b0;

  initial begin
    for (int i = 0; i < STORE_SIZE; i++) begin
      shadow_store[i] = (i < SPLASH_BYTES) ? SPLASH_ROM[i] : 8'h00;
    end
    shadow_pos     = 0;
    shadow_rot     = 2'd0;
    shadow_trailer = 1'b1;
  end

  // Maps logical coordinates through the rotation to a store byte and bit.
  // Returns 0 when the pixel lies outside the logical area.
  function automatic bit pixel_address(input logic [7:0] xr, input logic [7:0] yr,
                                       output int idx, output int bitn);
    int lw, lh, xs, ys, col, row;
    xs = $signed(xr);
    ys = $signed(yr);
    lw = shadow_rot[0] ? DISP_H : DISP_W;
    lh = shadow_rot[0] ? DISP_W : DISP_H;
    idx  = 0;
    bitn = 0;
    if (xs < 0 || xs >= lw || ys < 0 || ys >= lh) begin
      return 1'b0;
    end
    case (shadow_rot)
      2'd1: begin
        col = ys;
        row = DISP_H - 1 - xs;
      end
      2'd2: begin
        col = DISP_W - 1 - xs;
        row = DISP_H - 1 - ys;
      end
      2'd3: begin
        col = DISP_W - 1 - ys;
        row = xs;
      end
      default: begin
        col = xs;
        row = ys;
      end
    endcase
    idx  = col + (row / 8) * DISP_W;
    bitn = row % 8;
    return 1'b1;
  endfunction

  // Applies one accepted command to the shadow state and queues any result.
  task automatic apply_command(input fb_cmd_t c);
    fb_result_t r;
    int idx, bitn, total, page, off;
    r = '0;
    case (c.op)
      OP_WRITE: begin
        if (pixel_address(c.x, c.y, idx, bitn)) begin
          shadow_store[idx][bitn] = c.ink;
        end
      end
      OP_READ: begin
        r.kind = KIND_PIXEL;
        if (pixel_address(c.x, c.y, idx, bitn)) begin
          r.pixel = shadow_store[idx][bitn];
        end
        results_due.push_back(r);
      end
      OP_CLEAR: begin
        for (int i = 0; i < STORE_SIZE; i++) begin
          shadow_store[i] = 8'h00;
        end
      end
      default: begin
        total = FRAME_BODY + (shadow_trailer ? 1 : 0);
        // A pointer left past a frame that has just been shortened starts over.
        if (shadow_pos >= total) begin
          shadow_pos = 0;
        end
        r.kind = KIND_REFRESH;
        if (shadow_pos >= FRAME_BODY) begin
          r.out_byte = CMD_PAGE;
          r.is_cmd   = 1'b1;
        end else begin
          page = shadow_pos / PER_PAGE;
          off  = shadow_pos % PER_PAGE;
          if (off == 0) begin
            r.out_byte = CMD_PAGE | 8'(page);
            r.is_cmd   = 1'b1;
          end else if (off == 1) begin
            r.out_byte = CMD_COLUMN;
            r.is_cmd   = 1'b1;
          end else begin
            r.out_byte = shadow_store[page * DISP_W + off - 2];
          end
        end
        r.last     = (shadow_pos + 1 == total);
        shadow_pos = r.last ? 0 : shadow_pos + 1;
        results_due.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Rising edge: record handshakes, predict accepted commands, check result words,
  // and run the watchdog. Prediction comes first so the queue order stays FIFO.
  always @(posedge clk_i) begin : scoreboard
    fb_result_t want;
    bit         s_fire, m_fire;
    int         quiet;
    s_fire = s_valid && s_axis_tready_o;
    m_fire = m_axis_tvalid_o && m_rdy;
    s_took <= s_fire;
    m_took <= m_fire;
    if (s_fire) begin
      apply_command(s_cmd);
    end
    if (m_fire) begin
      if (results_due.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual tdata %0h tuser %0h",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", want.kind, m_axis_tuser_o[0]);
        check_field("pixel", want.pixel, m_axis_tdata_o[0]);
        check_field("out_byte", want.out_byte, m_axis_tdata_o[8:1]);
        check_field("is_command", want.is_cmd, m_axis_tuser_o[1]);
        check_field("last_of_frame", want.last, m_axis_tlast_o);
      end
    end
    // The watchdog only counts while something is owed in either direction.
    if (s_fire || m_fire || cfg_valid && cfg_ready_o ||
        (cmd_q.size() == 0 && !s_valid && results_due.size() == 0)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG) begin
      $display("paged_mono_framebuffer_core_tb: errors");
      $finish;
    end
  end

  // Sender: a word stays up until taken; between words it may idle at random.
  always @(negedge clk_i) begin : sender
    int gap_left;
    if (!s_valid || s_took) begin
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        s_cmd   <= cmd_q.pop_front();
        s_valid <= 1'b1;
        gap_left = calm ? 0 : $urandom_range(0, 4);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: it may stall at random after each taken word; on request it holds
  // off for a long stretch so the output register fills and the input backs up.
  always @(negedge clk_i) begin : receiver
    int  wait_left;
    int  hold_left;
    bit  hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF;
    end
    if (m_took) begin
      wait_left = calm ? 0 : $urandom_range(0, 4);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_rdy <= 1'b0;
    end else if (wait_left > 0) begin
      wait_left--;
      m_rdy <= 1'b0;
    end else begin
      m_rdy <= 1'b1;
    end
  end

  // Writes one register over the configuration channel and mirrors it.
  task automatic write_reg(input logic idx, input logic [1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (idx == REG_ROTATION) begin
      shadow_rot = value;
    end else begin
      shadow_trailer = value[0];
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every word is taken and every result has come, then lets a
  // possible clear run out so the block is idle.
  task automatic drain();
    while (cmd_q.size() > 0 || s_valid || results_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_cmd(input opcode_e op, input int x, input int y, input bit ink);
    fb_cmd_t c;
    c.op  = op;
    c.x   = 8'(x);
    c.y   = 8'(y);
    c.ink = ink;
    cmd_q.push_back(c);
  endtask

  // Reads at the four corners of the current logical area and just past them.
  task automatic push_corners();
    int lw, lh;
    lw = shadow_rot[0] ? DISP_H : DISP_W;
    lh = shadow_rot[0] ? DISP_W : DISP_H;
    push_cmd(OP_READ, 0, 0, 0);
    push_cmd(OP_READ, lw - 1, lh - 1, 0);
    push_cmd(OP_READ, lw - 1, 0, 0);
    push_cmd(OP_READ, 0, lh - 1, 0);
    push_cmd(OP_READ, lw, 0, 0);
    push_cmd(OP_READ, 0, lh, 0);
  endtask

  // Random word: mostly pixels in the logical area, some anywhere in the signed
  // range, a steady share of refreshes, an occasional clear unless fetch_only.
  task automatic push_random(input int count, input bit fetch_only);
    int lw, lh, pick, x, y;
    opcode_e op;
    lw = shadow_rot[0] ? DISP_H : DISP_W;
    lh = shadow_rot[0] ? DISP_W : DISP_H;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (fetch_only) begin
        op = (pick < 50) ? OP_READ : OP_REFRESH;
      end else if (pick < 35) begin
        op = OP_WRITE;
      end else if (pick < 60) begin
        op = OP_READ;
      end else if (pick < 63) begin
        op = OP_CLEAR;
      end else begin
        op = OP_REFRESH;
      end
      if ($urandom_range(0, 5) == 0) begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end else begin
        x = $urandom_range(0, lw - 1);
        y = $urandom_range(0, lh - 1);
      end
      push_cmd(op, x, y, $urandom_range(0, 1));
    end
  endtask

  typedef struct {
    logic [1:0] rot;
    logic       trailer;
  } fb_setting_t;

  fb_setting_t settings [8] = '{
    '{2'd0, 1'b1}, '{2'd1, 1'b0}, '{2'd2, 1'b1}, '{2'd3, 1'b0},
    '{2'd3, 1'b1}, '{2'd0, 1'b0}, '{2'd1, 1'b1}, '{2'd2, 1'b0}
  };

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_ROTATION, 2'd0);
    write_reg(REG_TRAILER, 2'd1);

    // Directed part at the reset settings, against the splash image.
    push_cmd(OP_READ, 0, 0, 0);
    push_cmd(OP_READ, DISP_W - 1, DISP_H - 1, 0);
    push_cmd(OP_READ, 38, 6, 0);            // a set bit of the splash image
    push_cmd(OP_READ, DISP_W, 0, 0);        // just right of the area
    push_cmd(OP_READ, 0, DISP_H, 0);        // just below the area
    push_cmd(OP_READ, -1, 0, 0);
    push_cmd(OP_READ, -128, -128, 0);
    push_cmd(OP_READ, 127, 127, 0);
    push_cmd(OP_WRITE, DISP_W - 1, DISP_H - 1, 1);
    push_cmd(OP_READ, DISP_W - 1, DISP_H - 1, 0);
    push_cmd(OP_WRITE, 38, 6, 0);
    push_cmd(OP_READ, 38, 6, 0);
    push_cmd(OP_WRITE, -1, 3, 1);           // outside: must leave the store alone
    push_cmd(OP_WRITE, DISP_W, 0, 1);
    push_cmd(OP_READ, 0, 3, 0);
    push_cmd(OP_REFRESH, 0, 0, 0);
    push_cmd(OP_REFRESH, 0, 0, 0);
    push_cmd(OP_REFRESH, 0, 0, 0);
    push_cmd(OP_CLEAR, 0, 0, 0);
    push_cmd(OP_REFRESH, 0, 0, 0);          // clear does not move the pointer
    push_cmd(OP_REFRESH, 0, 0, 0);
    push_cmd(OP_READ, 39, 7, 0);
    push_cmd(OP_WRITE, 2, 0, 1);
    push_cmd(OP_READ, 2, 0, 0);
    drain();

    // Random phases, one per register setting.
    foreach (settings[p]) begin
      write_reg(REG_ROTATION, settings[p].rot);
      write_reg(REG_TRAILER, {1'b0, settings[p].trailer});
      calm = (p == 4);
      push_corners();
      if (p == 2) begin
        // Long receiver hold-off while the sender keeps offering reads and fetches.
        hold_req = ~hold_req;
        push_random(40, 1'b1);
      end
      push_random(60, 1'b0);
      if (p == 5) begin
        // Sender stops until every owed result has arrived, then goes on.
        while (cmd_q.size() > 0 || s_valid || results_due.size() > 0) begin
          @(posedge clk_i);
        end
      end
      push_random(60, 1'b0);
      drain();
    end

    // Shortened frame: walk the pointer onto the trailing command, then drop
    // the trailer so the next fetch has to start a fresh frame.
    write_reg(REG_TRAILER, 2'd1);
    for (int n = shadow_pos; n < FRAME_BODY; n++) begin
      push_cmd(OP_REFRESH, 0, 0, 0);
    end
    drain();
    write_reg(REG_TRAILER, 2'd0);
    push_random(40, 1'b1);
    for (int n = 0; n < FRAME_BODY; n++) begin
      push_cmd(OP_REFRESH, $urandom_range(0, 255), $urandom_range(0, 255), 0);
    end
    drain();

    if (errors == 0 && results_due.size() == 0) begin
      $display("paged_mono_framebuffer_core_tb: clean");
    end else begin
      $display("paged_mono_framebuffer_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pmfb_pkg.sv
design/pmfb_ctrl.sv
design/pmfb_datapath.sv
design/paged_mono_framebuffer_core.sv
test/paged_mono_framebuffer_core_tb.sv
